FILE: hdl/bbot_pkg.sv
// ----------------------------------------------------------------------------
// bbot_pkg: shared types and constants for the bounding box overlap table
// opcodes, rectangle layout, controller states and coordinate key helper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbot_pkg;

  localparam int COORD_WIDTH      = 32;
  localparam int MAX_REGIONS_DEF  = 64;
  localparam int OPCODE_WIDTH     = 2;
  localparam int COUNT_OUT_WIDTH  = 7;
  localparam int S_DATA_WIDTH     = 2 * COORD_WIDTH;
  localparam int M_DATA_WIDTH     = 16;

  localparam logic [OPCODE_WIDTH-1:0] OP_QUERY = 2'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_ADD   = 2'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR = 2'd2;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  // coordinates held in offset binary so that they compare unsigned
  typedef struct packed {
    coord_t max_y;
    coord_t min_y;
    coord_t max_x;
    coord_t min_x;
  } rect_t;

  typedef struct packed {
    logic load;
    logic finish;
    logic clear;
  } box_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  function automatic coord_t to_key(input coord_t v);
    to_key = v ^ {1'b1, {(COORD_WIDTH-1){1'b0}}};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bbot_box.sv
// ----------------------------------------------------------------------------
// bbot_box: running bounding box of the current point set
// grows min/max in x and y per point, restarts after the last point or a clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbot_box (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bbot_pkg::box_ctrl_t ctrl,
  input  wire bbot_pkg::coord_t   x_key,
  input  wire bbot_pkg::coord_t   y_key,
  output bbot_pkg::rect_t         box,
  output bbot_pkg::rect_t         box_next
);

  logic set_started;

  always_comb begin
    box_next = box;
    if (!set_started) begin
      box_next.min_x = x_key;
      box_next.max_x = x_key;
      box_next.min_y = y_key;
      box_next.max_y = y_key;
    end else begin
      if (x_key < box.min_x) box_next.min_x = x_key;
      if (x_key > box.max_x) box_next.max_x = x_key;
      if (y_key < box.min_y) box_next.min_y = y_key;
      if (y_key > box.max_y) box_next.max_y = y_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_started <= 1'b0;
      box         <= '0;
    end else if (ctrl.clear) begin
      set_started <= 1'b0;
    end else if (ctrl.load) begin
      box         <= box_next;
      set_started <= !ctrl.finish;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bounding_box_overlap_table.sv
// ----------------------------------------------------------------------------
// bounding_box_overlap_table: point-set bounding boxes against a region table
// query sets test for overlap with stored rectangles, add sets append to it
// ----------------------------------------------------------------------------
// Points stream in one beat each; tlast closes a set and tuser holds the
// opcode (0 query, 1 add, 2 clear). A point that is not the last gives no
// result. An add or a clear goes through the EMIT state to the output
// register. A query's last point scans the rectangle memory one entry per
// cycle over its single read port, then goes to EMIT. Edges that touch
// count as overlap. Results wait in an output register; further points are
// taken while one is pending.
`timescale 1ns / 1ps
`default_nettype none

module bounding_box_overlap_table #(
  parameter int MAX_REGIONS = bbot_pkg::MAX_REGIONS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] x, [63:32] y
  input  wire logic [bbot_pkg::S_DATA_WIDTH-1:0] s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  // [1:0] opcode
  input  wire logic [bbot_pkg::OPCODE_WIDTH-1:0] s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] overlaps, [1] added, [2] table_full, [9:3] region_count, [15:10] zero
  output logic [bbot_pkg::M_DATA_WIDTH-1:0]      m_axis_tdata
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RW = $bits(bbot_pkg::rect_t);
  localparam int OW = bbot_pkg::COUNT_OUT_WIDTH;

  bbot_pkg::state_t    state, state_next;
  bbot_pkg::box_ctrl_t box_ctrl;
  bbot_pkg::rect_t     box, box_next, rd_rect;
  bbot_pkg::coord_t    x_key, y_key;

  logic [RW-1:0] mem [MAX_REGIONS];
  logic [RW-1:0] rd_data;

  logic [CW-1:0]    count;
  logic [CW-1:0]    scan_idx;
  logic [CW+OW-1:0] count_ext;
  logic             rd_pend;
  logic             hit;
  logic             res_added;
  logic             res_full;
  logic             out_valid;
  logic [OW-1:0]    out_count;
  logic             out_overlaps;
  logic             out_added;
  logic             out_full;

  logic accept;
  logic is_point;
  logic scan_more;
  logic scan_done;
  logic emit_load;
  logic has_room;
  logic meets;

  assign x_key = bbot_pkg::to_key(s_axis_tdata[bbot_pkg::COORD_WIDTH-1:0]);
  assign y_key = bbot_pkg::to_key(s_axis_tdata[bbot_pkg::S_DATA_WIDTH-1:bbot_pkg::COORD_WIDTH]);

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_point  = (s_axis_tuser == bbot_pkg::OP_QUERY) || (s_axis_tuser == bbot_pkg::OP_ADD);
  assign has_room  = count < CW'(MAX_REGIONS);
  assign scan_more = scan_idx < count;
  assign scan_done = !scan_more && !rd_pend;
  assign rd_rect   = bbot_pkg::rect_t'(rd_data);

  // inclusive compare: touching edges and corners overlap
  assign meets = (box.min_x <= rd_rect.max_x) && (rd_rect.min_x <= box.max_x) &&
                 (box.min_y <= rd_rect.max_y) && (rd_rect.min_y <= box.max_y);

  bbot_box u_box (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (box_ctrl),
    .x_key    (x_key),
    .y_key    (y_key),
    .box      (box),
    .box_next (box_next)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bbot_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == bbot_pkg::OP_CLEAR) begin
            state_next = bbot_pkg::ST_EMIT;
          end else if (is_point && s_axis_tlast) begin
            if (s_axis_tuser == bbot_pkg::OP_QUERY) state_next = bbot_pkg::ST_SCAN;
            else state_next = bbot_pkg::ST_EMIT;
          end
        end
      end
      bbot_pkg::ST_SCAN: begin
        if (scan_done) state_next = bbot_pkg::ST_EMIT;
      end
      bbot_pkg::ST_EMIT: begin
        if (!out_valid || m_axis_tready) state_next = bbot_pkg::ST_IDLE;
      end
      default: state_next = bbot_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready   = 1'b0;
    emit_load       = 1'b0;
    box_ctrl        = '0;
    unique case (state)
      bbot_pkg::ST_IDLE: begin
        s_axis_tready   = 1'b1;
        box_ctrl.load   = accept && is_point;
        box_ctrl.finish = accept && is_point && s_axis_tlast;
        box_ctrl.clear  = accept && (s_axis_tuser == bbot_pkg::OP_CLEAR);
      end
      bbot_pkg::ST_SCAN: begin
      end
      bbot_pkg::ST_EMIT: begin
        emit_load = !out_valid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbot_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // region memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == bbot_pkg::ST_IDLE && box_ctrl.finish &&
        s_axis_tuser == bbot_pkg::OP_ADD && has_room) begin
      mem[count[AW-1:0]] <= RW'(box_next);
    end
    rd_data <= mem[scan_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      res_added <= 1'b0;
      res_full  <= 1'b0;
    end else begin
      if (box_ctrl.clear) begin
        count     <= '0;
        hit       <= 1'b0;
        res_added <= 1'b0;
        res_full  <= 1'b0;
      end else if (box_ctrl.finish) begin
        hit      <= 1'b0;
        scan_idx <= '0;
        rd_pend  <= 1'b0;
        if (s_axis_tuser == bbot_pkg::OP_ADD) begin
          res_added <= has_room;
          res_full  <= !has_room;
          if (has_room) count <= CW'(count + 1'b1);
        end else begin
          res_added <= 1'b0;
          res_full  <= 1'b0;
        end
      end
      if (state == bbot_pkg::ST_SCAN) begin
        // address issued this cycle, data compared the next
        rd_pend <= scan_more;
        if (scan_more) scan_idx <= CW'(scan_idx + 1'b1);
        if (rd_pend && meets) hit <= 1'b1;
      end
    end
  end

  assign count_ext = (CW+OW)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_overlaps <= hit;
      out_added    <= res_added;
      out_full     <= res_full;
      out_count    <= count_ext[OW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(bbot_pkg::M_DATA_WIDTH-OW-3){1'b0}},
                          out_count, out_full, out_added, out_overlaps};

endmodule

`default_nettype wire
